// File: sv/mdm_pkg.sv
// Shared types and constants for the management-bus master.
// Used by mdm_core and mdio_management_master; no dependencies.
package mdm_pkg;

	// request kinds carried in s_tuser
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	// frame phases
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_PRE   = 3'd1;
	localparam logic [2:0] PH_HDR   = 3'd2;
	localparam logic [2:0] PH_TA    = 3'd3;
	localparam logic [2:0] PH_RDATA = 3'd4;
	localparam logic [2:0] PH_TRAIL = 3'd5;

	// header lengths, opcodes, turnaround
	localparam logic [5:0] HDR_BITS_RD = 6'd14;
	localparam logic [5:0] HDR_BITS_WR = 6'd32;
	localparam logic [5:0] TA_BITS     = 6'd2;
	localparam logic [5:0] DATA_BITS   = 6'd16;
	localparam logic [3:0] SOF_OP_RD   = 4'h6;
	localparam logic [3:0] SOF_OP_WR   = 4'h5;
	localparam logic [1:0] TA_WR       = 2'b10;

	// configuration registers
	localparam logic CFG_PREAMBLE = 1'b0;
	localparam logic CFG_IDLE_RD  = 1'b1;
	localparam logic [5:0] PREAMBLE_RST = 6'd8;
	localparam logic [3:0] IDLE_RD_RST  = 4'd8;

	// one request as taken from the input register
	typedef struct packed {
		logic [1:0]  req_type;
		logic [4:0]  phy_addr;
		logic [4:0]  reg_addr;
		logic [15:0] wr_data;
		logic        mdio_in;
	} req_t;

	// one result
	typedef struct packed {
		logic        mdio_out;
		logic        mdio_drive;
		logic        clock_pulse;
		logic [15:0] read_value;
		logic        frame_done;
		logic        busy_res;
		logic        request_rejected;
	} res_t;

	typedef struct packed {
		logic [5:0] preamble_bits;
		logic [3:0] idle_after_read;
	} cfg_t;

endpackage

// File: sv/mdm_core.sv
// Frame sequencer: phase, bit counter and shift registers, one tick per step.
// Depends on mdm_pkg.
module mdm_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  mdm_pkg::req_t req,
	input  mdm_pkg::cfg_t cfg,
	output mdm_pkg::res_t res
);

	logic [2:0]  phase_q, phase_d;
	logic [5:0]  bit_cnt_q, bit_cnt_d;
	logic [31:0] out_shift_q, out_shift_d;
	logic [15:0] in_shift_q, in_shift_d;
	logic        is_read_q, is_read_d;

	logic        busy;
	logic        start;
	logic [5:0]  cnt_dec;
	logic [31:0] new_shift;
	logic        new_read;

	always_comb begin
		busy     = (phase_q >= mdm_pkg::PH_PRE) && (phase_q <= mdm_pkg::PH_TRAIL);
		start    = (req.req_type == mdm_pkg::REQ_READ) || (req.req_type == mdm_pkg::REQ_WRITE);
		cnt_dec  = bit_cnt_q - 6'd1;
		new_read = (req.req_type == mdm_pkg::REQ_READ);
		if (new_read) begin
			new_shift = {mdm_pkg::SOF_OP_RD, req.phy_addr, req.reg_addr, 18'd0};
		end else begin
			new_shift = {mdm_pkg::SOF_OP_WR, req.phy_addr, req.reg_addr,
				mdm_pkg::TA_WR, req.wr_data};
		end

		phase_d     = phase_q;
		bit_cnt_d   = bit_cnt_q;
		out_shift_d = out_shift_q;
		in_shift_d  = in_shift_q;
		is_read_d   = is_read_q;
		res         = '0;

		if (start) begin
			if (busy) begin
				res.request_rejected = 1'b1;
				if (phase_q == mdm_pkg::PH_PRE) begin
					res.mdio_drive = 1'b1;
					res.mdio_out   = 1'b1;
				end else if (phase_q == mdm_pkg::PH_HDR) begin
					res.mdio_drive = 1'b1;
					res.mdio_out   = out_shift_q[31];
				end
			end else begin
				is_read_d   = new_read;
				out_shift_d = new_shift;
				in_shift_d  = '0;
				res.mdio_drive = 1'b1;
				if (cfg.preamble_bits == '0) begin
					phase_d      = mdm_pkg::PH_HDR;
					bit_cnt_d    = new_read ? mdm_pkg::HDR_BITS_RD : mdm_pkg::HDR_BITS_WR;
					res.mdio_out = new_shift[31];
				end else begin
					phase_d      = mdm_pkg::PH_PRE;
					bit_cnt_d    = cfg.preamble_bits;
					res.mdio_out = 1'b1;
				end
			end
		end else if (busy) begin
			res.clock_pulse = 1'b1;
			bit_cnt_d = cnt_dec;
			unique case (phase_q)
				mdm_pkg::PH_PRE: begin
					res.mdio_out   = 1'b1;
					res.mdio_drive = 1'b1;
					if (cnt_dec == '0) begin
						phase_d   = mdm_pkg::PH_HDR;
						bit_cnt_d = is_read_q ? mdm_pkg::HDR_BITS_RD : mdm_pkg::HDR_BITS_WR;
					end
				end
				mdm_pkg::PH_HDR: begin
					res.mdio_out   = out_shift_q[31];
					res.mdio_drive = 1'b1;
					out_shift_d    = {out_shift_q[30:0], 1'b0};
					if (cnt_dec == '0) begin
						if (is_read_q) begin
							phase_d   = mdm_pkg::PH_TA;
							bit_cnt_d = mdm_pkg::TA_BITS;
						end else begin
							phase_d        = mdm_pkg::PH_IDLE;
							res.frame_done = 1'b1;
						end
					end
				end
				mdm_pkg::PH_TA: begin
					if (cnt_dec == '0) begin
						phase_d   = mdm_pkg::PH_RDATA;
						bit_cnt_d = mdm_pkg::DATA_BITS;
					end
				end
				mdm_pkg::PH_RDATA: begin
					in_shift_d = {in_shift_q[14:0], req.mdio_in};
					if (cnt_dec == '0) begin
						if (cfg.idle_after_read == '0) begin
							phase_d        = mdm_pkg::PH_IDLE;
							res.frame_done = 1'b1;
							res.read_value = in_shift_d;
						end else begin
							phase_d   = mdm_pkg::PH_TRAIL;
							bit_cnt_d = {2'b00, cfg.idle_after_read};
						end
					end
				end
				default: begin
					// trailing idle clocks
					if (cnt_dec == '0) begin
						phase_d        = mdm_pkg::PH_IDLE;
						res.frame_done = 1'b1;
						res.read_value = in_shift_q;
					end
				end
			endcase
		end else begin
			// idle tick; unused codes fall back to idle
			phase_d = mdm_pkg::PH_IDLE;
		end

		res.busy_res = (phase_d >= mdm_pkg::PH_PRE) && (phase_d <= mdm_pkg::PH_TRAIL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mdm_pkg::PH_IDLE;
			bit_cnt_q   <= '0;
			out_shift_q <= '0;
			in_shift_q  <= '0;
			is_read_q   <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			bit_cnt_q   <= bit_cnt_d;
			out_shift_q <= out_shift_d;
			in_shift_q  <= in_shift_d;
			is_read_q   <= is_read_d;
		end
	end

endmodule

// File: sv/mdio_management_master.sv
// Top level of the clause 22 style management-bus master.
// Holds the input register, config registers and result register; depends on
// mdm_pkg and mdm_core.
//
// Usage:
//  - Each request on the s_ side is one management clock tick or a frame start
//    (s_tuser: tick, read, write). Every request yields exactly one result on
//    the m_ side: line level, drive enable, clock pulse flag, read data, busy
//    and reject flags; m_tlast marks the tick that finishes a frame.
//  - A request is taken into the input register, then a sequencer step writes
//    its result into the result register.
//  - Throughput: one request per cycle while m_tready is high. The sequencer
//    handles a tick with a counter decrement and a one-bit shift, so nothing loops over cycles.
//  - When m_tready is low the result register holds; one further request can
//    wait in the input register, after which s_tready drops.
//  - Reset (arst_n low) empties both registers, returns the sequencer to idle
//    and loads preamble_bits = 8, idle_after_read = 8.
//  - APB: preamble_bits at 0x0, idle_after_read at 0x4; pready is always high.
//    Change them only while no frame is in progress.
module mdio_management_master (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // phy_addr[4:0], reg_addr[9:5], wr_data[25:10],
	                              // mdio_in[26], zero[31:27]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // mdio_out[0], mdio_drive[1], clock_pulse[2],
	                              // read_value[18:3], busy_res[19],
	                              // request_rejected[20], zero[23:21]
	output logic        m_tlast,  // frame_done
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic          valid_s1;
	mdm_pkg::req_t req_s1;
	logic          advance;

	mdm_pkg::cfg_t cfg_q;
	mdm_pkg::res_t res;
	mdm_pkg::res_t res_q;
	logic          out_valid_q;

	// pipeline handshake: step when a request is held and the result slot frees
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.req_type <= s_tuser;
			req_s1.phy_addr <= s_tdata[4:0];
			req_s1.reg_addr <= s_tdata[9:5];
			req_s1.wr_data  <= s_tdata[25:10];
			req_s1.mdio_in  <= s_tdata[26];
		end
	end

	// config registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preamble_bits   <= mdm_pkg::PREAMBLE_RST;
			cfg_q.idle_after_read <= mdm_pkg::IDLE_RD_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == mdm_pkg::CFG_PREAMBLE) begin
				cfg_q.preamble_bits <= pwdata[5:0];
			end else begin
				cfg_q.idle_after_read <= pwdata[3:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == mdm_pkg::CFG_IDLE_RD) begin
			prdata = {28'd0, cfg_q.idle_after_read};
		end else begin
			prdata = {26'd0, cfg_q.preamble_bits};
		end
	end

	// frame sequencer
	mdm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = res_q.frame_done;
	assign m_tdata  = {3'd0, res_q.request_rejected, res_q.busy_res, res_q.read_value,
		res_q.clock_pulse, res_q.mdio_drive, res_q.mdio_out};

endmodule
